/* hw/rtl/fmpd_pkg.sv */
// Shared constants, types and the CORDIC angle table of the FM phase discriminator.
`default_nettype none

package fmpd_pkg;

  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int PHASE_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int GUARD_BITS = 8;
  localparam int ATAN_DEPTH = 24;
  localparam int RATE_BITS  = 27;
  localparam int ENV_BITS   = 16;
  localparam int GAIN_BITS  = 16;

  localparam logic [GAIN_BITS-1:0] INV_GAIN_Q16 = 16'd39797;
  localparam logic [RATE_BITS-1:0] RATE_RESET   = 27'd40000000;
  localparam logic [31:0]          HALF_TURN    = 32'h8000_0000;

  // Side information that travels down the chain next to each sample.
  typedef struct packed {
    logic zero;
    logic restart;
  } fmpd_tag_t;

  // atan(2^-s) as a fraction of a full turn, scaled by 2^32.
  function automatic logic [31:0] atan_turn32(input int unsigned s);
    logic [31:0] a;
    case (s)
      0:       a = 32'h20000000;
      1:       a = 32'h12E4051E;
      2:       a = 32'h09FB385B;
      3:       a = 32'h051111D4;
      4:       a = 32'h028B0D43;
      5:       a = 32'h0145D7E1;
      6:       a = 32'h00A2F61E;
      7:       a = 32'h00517C55;
      8:       a = 32'h0028BE53;
      9:       a = 32'h00145F2F;
      10:      a = 32'h000A2F98;
      11:      a = 32'h000517CC;
      12:      a = 32'h00028BE6;
      13:      a = 32'h000145F3;
      14:      a = 32'h0000A2FA;
      15:      a = 32'h0000517D;
      16:      a = 32'h000028BE;
      17:      a = 32'h0000145F;
      18:      a = 32'h00000A30;
      19:      a = 32'h00000518;
      20:      a = 32'h0000028C;
      21:      a = 32'h00000146;
      22:      a = 32'h000000A3;
      23:      a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/fm_phase_discriminator_top.sv */
// Top level of the FM phase discriminator: CORDIC cell chain and discriminator output stage.
//
// Input channel: in_valid/in_ready carry one analytic sample (i_sample, q_sample) plus a
// restart flag per transaction. Output channel: out_valid/out_ready carry freq_hz, the
// phase step to the previous sample scaled by the sample rate, and envelope, the
// gain-compensated magnitude. One result comes out for every sample, in order. The user
// must write the sample rate register via cfg_wr_en/cfg_wr_data while the block idles.
//
// The chain is one pre-rotation cell, one cell per CORDIC micro-rotation, one rounding and
// multiply cell and the discriminator output register. Throughput is one sample per clock
// while out_ready stays high; every cell of the chain holds one sample.
//
// Synchronous reset empties the chain, sets the rate to 40 MHz, clears the previous
// phase and marks the next sample as the first, which gives frequency zero.
// When the receiver stalls, the output register holds its result and each cell still
// takes a sample while the cell after it is empty or moving, so input stops only
// once the whole chain is full.
`default_nettype none

module fm_phase_discriminator_top #(
  parameter int SAMPLE_BITS   = fmpd_pkg::SAMPLE_BITS_DEF,
  parameter int PHASE_BITS    = fmpd_pkg::PHASE_BITS_DEF,
  parameter int CORDIC_STAGES = fmpd_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [fmpd_pkg::RATE_BITS-1:0] cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
  input  wire logic signed [SAMPLE_BITS-1:0] q_sample,
  input  wire logic                          restart,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [fmpd_pkg::RATE_BITS-1:0]     freq_hz,
  output logic [fmpd_pkg::ENV_BITS-1:0]      envelope
);
  import fmpd_pkg::*;

  // Three bits above the guard-scaled sample cover the CORDIC gain and the sign.
  localparam int W  = SAMPLE_BITS + GUARD_BITS + 3;
  localparam int MW = W - 1 + GAIN_BITS;

  logic signed [W-1:0] x_chain     [CORDIC_STAGES+1];
  logic signed [W-1:0] y_chain     [CORDIC_STAGES+1];
  logic [31:0]         z_chain     [CORDIC_STAGES+1];
  fmpd_tag_t           tag_chain   [CORDIC_STAGES+1];
  logic                valid_chain [CORDIC_STAGES+1];
  logic                ready_chain [CORDIC_STAGES+1];

  logic                  post_valid;
  logic                  post_ready;
  logic [PHASE_BITS-1:0] post_phase;
  logic [MW-1:0]         post_mag_prod;
  logic                  post_restart;

  fmpd_prerot #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .W          (W)
  ) u_prerot (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .i_sample (i_sample),
    .q_sample (q_sample),
    .restart  (restart),
    .out_valid(valid_chain[0]),
    .out_ready(ready_chain[0]),
    .x        (x_chain[0]),
    .y        (y_chain[0]),
    .z        (z_chain[0]),
    .tag      (tag_chain[0])
  );

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    fmpd_cordic_cell #(
      .W    (W),
      .SHIFT(k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (valid_chain[k]),
      .in_ready (ready_chain[k]),
      .x_in     (x_chain[k]),
      .y_in     (y_chain[k]),
      .z_in     (z_chain[k]),
      .tag_in   (tag_chain[k]),
      .out_valid(valid_chain[k+1]),
      .out_ready(ready_chain[k+1]),
      .x        (x_chain[k+1]),
      .y        (y_chain[k+1]),
      .z        (z_chain[k+1]),
      .tag      (tag_chain[k+1])
    );
  end

  fmpd_post #(
    .W         (W),
    .PHASE_BITS(PHASE_BITS)
  ) u_post (
    .clk      (clk),
    .rst      (rst),
    .in_valid (valid_chain[CORDIC_STAGES]),
    .in_ready (ready_chain[CORDIC_STAGES]),
    .x_in     (x_chain[CORDIC_STAGES]),
    .z_in     (z_chain[CORDIC_STAGES]),
    .tag_in   (tag_chain[CORDIC_STAGES]),
    .out_valid(post_valid),
    .out_ready(post_ready),
    .phase    (post_phase),
    .mag_prod (post_mag_prod),
    .restart  (post_restart)
  );

  fmpd_disc #(
    .W         (W),
    .PHASE_BITS(PHASE_BITS)
  ) u_disc (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (post_valid),
    .in_ready   (post_ready),
    .phase      (post_phase),
    .mag_prod   (post_mag_prod),
    .restart    (post_restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .freq_hz    (freq_hz),
    .envelope   (envelope)
  );

endmodule

`default_nettype wire

/* hw/rtl/fmpd_prerot.sv */
// Input cell: sign extension, guard scaling and half-turn pre-rotation of a sample.
`default_nettype none

module fmpd_prerot #(
  parameter int SAMPLE_BITS = 16,
  parameter int W           = 27
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
  input  wire logic signed [SAMPLE_BITS-1:0] q_sample,
  input  wire logic                         restart,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [W-1:0]               x,
  output logic signed [W-1:0]               y,
  output logic [31:0]                       z,
  output fmpd_pkg::fmpd_tag_t               tag
);
  import fmpd_pkg::*;

  logic                valid;
  logic                load;
  logic signed [W-1:0] x_ext;
  logic signed [W-1:0] y_ext;

  assign in_ready  = !valid || out_ready;
  assign load      = in_valid && in_ready;
  assign out_valid = valid;

  always_comb begin
    x_ext = W'(i_sample) <<< GUARD_BITS;
    y_ext = W'(q_sample) <<< GUARD_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      // A sample in the left half plane is turned by a half turn first.
      if (x_ext[W-1]) begin
        x <= -x_ext;
        y <= -y_ext;
        z <= HALF_TURN;
      end else begin
        x <= x_ext;
        y <= y_ext;
        z <= '0;
      end
      tag.zero    <= (i_sample == '0) && (q_sample == '0);
      tag.restart <= restart;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/fmpd_cordic_cell.sv */
// One vectoring CORDIC micro-rotation cell with its own pipeline register.
`default_nettype none

module fmpd_cordic_cell #(
  parameter int W     = 27,
  parameter int SHIFT = 0
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic signed [W-1:0] x_in,
  input  wire logic signed [W-1:0] y_in,
  input  wire logic [31:0]         z_in,
  input  wire fmpd_pkg::fmpd_tag_t tag_in,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [W-1:0]      x,
  output logic signed [W-1:0]      y,
  output logic [31:0]              z,
  output fmpd_pkg::fmpd_tag_t      tag
);
  import fmpd_pkg::*;

  localparam logic [31:0] ANGLE = atan_turn32(SHIFT);

  logic                valid;
  logic                load;
  logic                y_pos;
  logic signed [W-1:0] dx;
  logic signed [W-1:0] dy;

  assign in_ready  = !valid || out_ready;
  assign load      = in_valid && in_ready;
  assign out_valid = valid;

  always_comb begin
    dx    = y_in >>> SHIFT;
    dy    = x_in >>> SHIFT;
    y_pos = !y_in[W-1] && (y_in != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (y_pos) begin
        x <= x_in + dx;
        y <= y_in - dy;
        z <= z_in + ANGLE;
      end else begin
        x <= x_in - dx;
        y <= y_in + dy;
        z <= z_in - ANGLE;
      end
      tag <= tag_in;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/fmpd_post.sv */
// Output cell of the CORDIC: phase rounding and the gain-compensation multiply.
`default_nettype none

module fmpd_post #(
  parameter int W          = 27,
  parameter int PHASE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [W-1:0]           x_in,
  input  wire logic [31:0]                   z_in,
  input  wire fmpd_pkg::fmpd_tag_t           tag_in,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [PHASE_BITS-1:0]              phase,
  output logic [W-1+fmpd_pkg::GAIN_BITS-1:0] mag_prod,
  output logic                               restart
);
  import fmpd_pkg::*;

  localparam int MW = W - 1 + GAIN_BITS;

  logic          valid;
  logic          load;
  logic [31:0]   z_round;
  logic [W-2:0]  x_clamp;

  assign in_ready  = !valid || out_ready;
  assign load      = in_valid && in_ready;
  assign out_valid = valid;

  always_comb begin
    // Round half up to the phase width; the add wraps modulo a full turn.
    z_round = z_in + (32'd1 << (31 - PHASE_BITS));
    x_clamp = x_in[W-1] ? '0 : x_in[W-2:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      phase    <= tag_in.zero ? '0 : z_round[31 -: PHASE_BITS];
      mag_prod <= MW'(x_clamp) * MW'(INV_GAIN_Q16);
      restart  <= tag_in.restart;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/fmpd_disc.sv */
// Discriminator cell: phase step, frequency scaling, envelope saturation and output register.
`default_nettype none

module fmpd_disc #(
  parameter int W          = 27,
  parameter int PHASE_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_wr_en,
  input  wire logic [fmpd_pkg::RATE_BITS-1:0]      cfg_wr_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [PHASE_BITS-1:0]               phase,
  input  wire logic [W-1+fmpd_pkg::GAIN_BITS-1:0]  mag_prod,
  input  wire logic                                restart,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [fmpd_pkg::RATE_BITS-1:0]           freq_hz,
  output logic [fmpd_pkg::ENV_BITS-1:0]            envelope
);
  import fmpd_pkg::*;

  localparam int MW    = W - 1 + GAIN_BITS;
  localparam int MSH   = GAIN_BITS + GUARD_BITS;
  localparam int MBITS = MW + 1 - MSH;
  localparam int EXT   = MBITS + ENV_BITS;
  localparam int SW    = PHASE_BITS + RATE_BITS;

  logic                  valid;
  logic                  load;
  logic [RATE_BITS-1:0]  rate;
  logic [PHASE_BITS-1:0] prev_phase;
  logic                  first_pending;
  logic [PHASE_BITS-1:0] delta;
  logic [SW-1:0]         scaled;
  logic [MW:0]           mag_sum;
  logic [EXT-1:0]        mag_ext;
  logic [RATE_BITS-1:0]  freq_next;
  logic [ENV_BITS-1:0]   envelope_next;

  assign in_ready  = !valid || out_ready;
  assign load      = in_valid && in_ready;
  assign out_valid = valid;

  always_comb begin
    // The subtraction wraps, which puts the step in [0, 2pi).
    delta     = phase - prev_phase;
    scaled    = SW'(delta) * SW'(rate);
    freq_next = (first_pending || restart) ? '0 : scaled[PHASE_BITS +: RATE_BITS];

    mag_sum       = (MW + 1)'(mag_prod) + ((MW + 1)'(1) << (MSH - 1));
    mag_ext       = EXT'(mag_sum[MW:MSH]);
    envelope_next = (|mag_ext[EXT-1:ENV_BITS]) ? '1 : mag_ext[ENV_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= RATE_RESET;
    end else if (cfg_wr_en) begin
      rate <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= 1'b0;
      prev_phase    <= '0;
      first_pending <= 1'b1;
    end else begin
      if (in_ready) begin
        valid <= in_valid;
      end
      if (load) begin
        prev_phase    <= phase;
        first_pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      freq_hz  <= freq_next;
      envelope <= envelope_next;
    end
  end

  a_first_zero: assert property (@(posedge clk) disable iff (rst)
    load && (first_pending || restart) |=> freq_hz == '0)
    else $error("first transaction after reset or restart gave a nonzero frequency");

  a_first_clear: assert property (@(posedge clk) disable iff (rst)
    load |=> !first_pending)
    else $error("first_pending still set after a transaction");

  a_prev_track: assert property (@(posedge clk) disable iff (rst)
    load |=> prev_phase == $past(phase))
    else $error("previous phase did not follow the last transaction");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the FM phase discriminator: random handshakes, CORDIC prediction.
module tb_top;
  import fmpd_pkg::*;

  localparam int SBITS   = SAMPLE_BITS_DEF;
  localparam int LATENCY = CORDIC_STAGES_DEF + 3;
  localparam real TWO_PI = 6.283185307179586;

  // atan(2^-s) in units of 2^-32 turn, entry 0 in the low word.
  localparam logic [16*32-1:0] ATAN_TURN = {
    32'h0000517D, 32'h0000A2FA, 32'h000145F3, 32'h00028BE6,
    32'h000517CC, 32'h000A2F98, 32'h00145F2F, 32'h0028BE53,
    32'h00517C55, 32'h00A2F61E, 32'h0145D7E1, 32'h028B0D43,
    32'h051111D4, 32'h09FB385B, 32'h12E4051E, 32'h20000000
  };

  typedef struct {
    logic signed [SBITS-1:0] i;
    logic signed [SBITS-1:0] q;
    logic                    rs;
  } iq_sample_t;

  typedef struct {
    logic [RATE_BITS-1:0] freq;
    logic [ENV_BITS-1:0]  env;
  } fm_result_t;

  typedef struct {
    logic [15:0] phase;
    logic [15:0] mag;
  } polar_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_wr_en = 1'b0;
  logic [RATE_BITS-1:0]    cfg_wr_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [SBITS-1:0] i_sample = '0;
  logic signed [SBITS-1:0] q_sample = '0;
  logic                    restart = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [RATE_BITS-1:0]    freq_hz;
  logic [ENV_BITS-1:0]     envelope;

  // Predictor state.
  logic [RATE_BITS-1:0] rate_hz = RATE_RESET;
  logic [15:0]          prev_phase = '0;
  logic                 first_due = 1'b1;

  iq_sample_t pending_iq[$];
  fm_result_t due_results[$];
  int n_queued = 0;
  int n_accepted = 0;
  int n_results = 0;
  int errors = 0;
  int n_rates = 1;
  bit in_took = 1'b0;
  bit out_took = 1'b0;
  int in_gap = 0;
  int in_quiet = 0;
  int out_stall = 0;
  int out_quiet = 0;

  fm_phase_discriminator_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .i_sample   (i_sample),
    .q_sample   (q_sample),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .freq_hz    (freq_hz),
    .envelope   (envelope)
  );

  always #5 clk = ~clk;

  // Vectoring CORDIC: phase as a 16-bit binary angle, magnitude gain compensated.
  function automatic polar_t to_polar(input logic signed [SBITS-1:0] iv,
                                      input logic signed [SBITS-1:0] qv);
    longint x;
    longint y;
    longint dx;
    longint dy;
    logic [31:0] z;
    logic [32:0] z_rnd;
    longint unsigned m;
    int s;
    polar_t p;
    p.phase = '0;
    p.mag = '0;
    if (iv == 0 && qv == 0) begin
      return p;
    end
    x = longint'(iv) <<< GUARD_BITS;
    y = longint'(qv) <<< GUARD_BITS;
    z = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HALF_TURN;
    end
    for (s = 0; s < CORDIC_STAGES_DEF; s++) begin
      dx = y >>> s;
      dy = x >>> s;
      if (y > 0) begin
        x += dx;
        y -= dy;
        z += ATAN_TURN[s*32 +: 32];
      end else begin
        x -= dx;
        y += dy;
        z -= ATAN_TURN[s*32 +: 32];
      end
    end
    z_rnd = {1'b0, z} + 33'h8000;
    p.phase = z_rnd[31:16];
    if (x < 0) begin
      x = 0;
    end
    m = (longint'(x) * INV_GAIN_Q16 + (64'd1 << 23)) >> 24;
    p.mag = (m > 65535) ? 16'hFFFF : m[15:0];
    return p;
  endfunction

  // Phase step since the last sample, scaled by the sample rate.
  function automatic fm_result_t discriminate(input logic signed [SBITS-1:0] iv,
                                              input logic signed [SBITS-1:0] qv,
                                              input logic rs);
    polar_t p;
    logic [15:0] step;
    logic [63:0] prod;
    fm_result_t r;
    p = to_polar(iv, qv);
    r.freq = '0;
    if (!first_due && !rs) begin
      step = p.phase - prev_phase;
      prod = 64'(step) * 64'(rate_hz);
      r.freq = prod[16 +: RATE_BITS];
    end
    r.env = p.mag;
    prev_phase = p.phase;
    first_due = 1'b0;
    return r;
  endfunction

  function automatic int draw_wait(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      quiet = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("ERROR result %0d: %s got %0d, want %0d", n_results, what, got, want);
  endtask

  task automatic push_sample(input int iv, input int qv, input bit rs);
    iq_sample_t s;
    s.i = iv[SBITS-1:0];
    s.q = qv[SBITS-1:0];
    s.rs = rs;
    pending_iq.insert(pending_iq.size(), s);
    n_queued++;
  endtask

  // Mostly constant-frequency tone bursts with random amplitude, plus zero and raw noise samples.
  task automatic push_random(input int count);
    int kind;
    int len;
    int k;
    real amp;
    real ph;
    real step;
    while (count > 0) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        len = $urandom_range(4, 24);
        case ($urandom_range(0, 3))
          0:       amp = 32767.0;
          1:       amp = $urandom_range(1, 16);
          2:       amp = $urandom_range(100, 32767);
          default: amp = $urandom_range(16, 2000);
        endcase
        ph = TWO_PI * $urandom_range(0, 65535) / 65536.0;
        step = TWO_PI * $urandom_range(0, 65535) / 65536.0;
        for (k = 0; k < len && count > 0; k++) begin
          push_sample($rtoi(amp * $cos(ph)), $rtoi(amp * $sin(ph)),
                      k == 0 && $urandom_range(0, 3) == 0);
          ph += step;
          count--;
        end
      end else if (kind == 7) begin
        push_sample(0, 0, $urandom_range(0, 7) == 0);
        count--;
      end else begin
        push_sample($urandom_range(0, 65535), $urandom_range(0, 65535),
                    $urandom_range(0, 7) == 0);
        count--;
      end
    end
  endtask

  task automatic wait_drained();
    wait (n_accepted == n_queued && due_results.size() == 0);
  endtask

  task automatic write_rate(input logic [RATE_BITS-1:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    rate_hz = v;
    n_rates++;
  endtask

  // Input side: present the next sample after a random gap and hold it until taken.
  always @(negedge clk) begin
    iq_sample_t s;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      in_took = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_iq.size() > 0) begin
        s = pending_iq.pop_front();
        i_sample <= s.i;
        q_sample <= s.q;
        restart <= s.rs;
        in_valid <= 1'b1;
        in_gap = draw_wait(in_quiet);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output side: stall for a random number of cycles after every result.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_took) begin
        out_took = 1'b0;
        out_stall = draw_wait(out_quiet);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Both handshakes are sampled at the rising edge.
  always @(posedge clk) begin
    fm_result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        due_results.insert(due_results.size(), discriminate(i_sample, q_sample, restart));
        n_accepted++;
        in_took = 1'b1;
      end
      if (out_valid && out_ready) begin
        out_took = 1'b1;
        n_results++;
        if (due_results.size() == 0) begin
          report_mismatch("unexpected transaction, freq_hz", freq_hz, 0);
        end else begin
          want = due_results.pop_front();
          if (freq_hz !== want.freq) begin
            report_mismatch("freq_hz", freq_hz, want.freq);
          end
          if (envelope !== want.env) begin
            report_mismatch("envelope", envelope, want.env);
          end
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: axes, corners, zero samples, restarts, first sample after reset.
    push_sample(1000, 0, 1'b0);
    push_sample(0, 1000, 1'b0);
    push_sample(-1000, 0, 1'b0);
    push_sample(0, -1000, 1'b0);
    push_sample(0, 0, 1'b0);
    push_sample(32767, 0, 1'b0);
    push_sample(-32768, 0, 1'b0);
    push_sample(0, 32767, 1'b0);
    push_sample(0, -32768, 1'b0);
    push_sample(32767, 32767, 1'b0);
    push_sample(-32768, -32768, 1'b0);
    push_sample(-32768, 32767, 1'b0);
    push_sample(32767, -32768, 1'b0);
    push_sample(1, 0, 1'b1);
    push_sample(0, -1, 1'b0);
    push_sample(-1, -1, 1'b0);
    push_sample(-1, 1, 1'b0);
    push_sample(100, -100, 1'b1);
    push_sample(0, 0, 1'b0);
    push_sample(5000, 1, 1'b0);
    push_sample(-5000, -1, 1'b0);
    push_sample(-5000, 0, 1'b0);
    push_random(175);
    wait_drained();

    write_rate(27'd1);
    push_random(175);
    wait_drained();

    write_rate(27'd100000000);
    push_random(175);
    wait_drained();

    // The full register width is accepted even beyond the nominal range.
    write_rate({RATE_BITS{1'b1}});
    push_random(175);
    wait_drained();

    write_rate(27'd0);
    push_random(175);
    wait_drained();

    write_rate($urandom_range(1, 100000000));
    push_random(175);
    wait_drained();

    repeat (LATENCY + 8) @(posedge clk);
    $display("Ran %0d samples over %0d sample rate settings, %0d results checked.",
             n_accepted, n_rates, n_results);
    $display("Found %0d field mismatches.", errors);
    if (errors == 0) begin
      $display("fm_phase_discriminator_top: match");
    end else begin
      $display("fm_phase_discriminator_top: mismatch");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("Timeout with %0d of %0d samples taken.", n_accepted, n_queued);
    $display("fm_phase_discriminator_top: mismatch");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/fmpd_pkg.sv
hw/rtl/fmpd_prerot.sv
hw/rtl/fmpd_cordic_cell.sv
hw/rtl/fmpd_post.sv
hw/rtl/fmpd_disc.sv
hw/rtl/fm_phase_discriminator_top.sv
tb/tb_top.sv
